>>> hdl/minv_pkg.sv
// ----------------------------------------------------------------------------
// minv_pkg - shared types and arithmetic for the modular inverse core
// Word type, Euclid state record and the small mod-p helpers that both the
// step unit and the sequencer use.
// ----------------------------------------------------------------------------
package minv_pkg;

	localparam int unsigned VALUE_W = 30;

	typedef logic [VALUE_W-1:0] word_t;

	// fixed prime 1e9 + 7, fits in 30 bits
	localparam word_t MODULUS = 30'd1000000007;

	// working set of the binary extended Euclid: x1*a = u, x2*a = v (mod p)
	typedef struct packed {
		word_t u;
		word_t v;
		word_t x1;
		word_t x2;
	} euclid_t;

	// fold a raw 30-bit value into 0..p-1 (value < 2p always holds)
	function automatic word_t reduce_mod(word_t x);
		logic [VALUE_W:0] d;
		d = {1'b0, x} - {1'b0, MODULUS};
		return d[VALUE_W] ? x : d[VALUE_W-1:0];
	endfunction

	// x / 2 mod p for odd p: add p first when x is odd
	function automatic word_t half_mod(word_t x);
		logic [VALUE_W:0] s;
		s = x[0] ? ({1'b0, x} + {1'b0, MODULUS}) : {1'b0, x};
		return s[VALUE_W:1];
	endfunction

	// (a - b) mod p for a, b in 0..p-1
	function automatic word_t sub_mod(word_t a, word_t b);
		logic [VALUE_W:0] d;
		logic [VALUE_W:0] c;
		d = {1'b0, a} - {1'b0, b};
		c = d + {1'b0, MODULUS};
		return d[VALUE_W] ? c[VALUE_W-1:0] : d[VALUE_W-1:0];
	endfunction

endpackage

>>> hdl/minv_req_if.sv
// ----------------------------------------------------------------------------
// minv_req_if - request channel of the modular inverse core
// Valid/ready channel carrying one value word.
// ----------------------------------------------------------------------------
interface minv_req_if;

	logic               valid;
	logic               ready;
	minv_pkg::word_t    value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

>>> hdl/minv_rsp_if.sv
// ----------------------------------------------------------------------------
// minv_rsp_if - response channel of the modular inverse core
// Valid/ready channel carrying the inverse and the no-inverse flag.
// ----------------------------------------------------------------------------
interface minv_rsp_if;

	logic               valid;
	logic               ready;
	minv_pkg::word_t    inverse;
	logic               no_inverse;

	modport source (output valid, output inverse, output no_inverse, input ready);
	modport sink   (input valid, input inverse, input no_inverse, output ready);

endinterface

>>> hdl/minv_step.sv
// ----------------------------------------------------------------------------
// minv_step - one iteration of the binary extended Euclid
// Halves an even remainder, or subtracts the smaller odd remainder from the
// larger and halves the difference, keeping the Bezout coefficients mod p.
// ----------------------------------------------------------------------------
module minv_step (
	input  minv_pkg::euclid_t  cur,
	output minv_pkg::euclid_t  nxt
);

	minv_pkg::word_t  diff_uv;
	minv_pkg::word_t  diff_vu;
	logic             u_ge_v;

	assign u_ge_v  = (cur.u >= cur.v);
	assign diff_uv = cur.u - cur.v;
	assign diff_vu = cur.v - cur.u;

	// pick the single operation for this cycle
	always_comb begin
		nxt = cur;
		if (!cur.u[0]) begin
			nxt.u  = {1'b0, cur.u[minv_pkg::VALUE_W-1:1]};
			nxt.x1 = minv_pkg::half_mod(cur.x1);
		end else if (!cur.v[0]) begin
			nxt.v  = {1'b0, cur.v[minv_pkg::VALUE_W-1:1]};
			nxt.x2 = minv_pkg::half_mod(cur.x2);
		end else if (u_ge_v) begin
			// both odd: difference is even, halve it straight away
			nxt.u  = {1'b0, diff_uv[minv_pkg::VALUE_W-1:1]};
			nxt.x1 = minv_pkg::half_mod(minv_pkg::sub_mod(cur.x1, cur.x2));
		end else begin
			nxt.v  = {1'b0, diff_vu[minv_pkg::VALUE_W-1:1]};
			nxt.x2 = minv_pkg::half_mod(minv_pkg::sub_mod(cur.x2, cur.x1));
		end
	end

endmodule

>>> hdl/modular_inverse_prime_core.sv
// ----------------------------------------------------------------------------
// modular_inverse_prime_core - inverse modulo 1000000007
// Accepts one 30-bit value word per request and returns its inverse mod the
// prime, or a no-inverse flag with inverse 0 for a multiple of the prime.
// ----------------------------------------------------------------------------
// A request word is folded into 0..p-1 on acceptance, then a shared step unit
// runs the binary extended Euclid, one halving or one subtract-and-halve per
// cycle, until a remainder reaches 1. Each step removes at least one bit from
// one of the two 30-bit remainders, so a run always ends. An item's time in
// the core is data dependent: the accepting cycle loads the state, the steps
// follow, and a final cycle writes the response register. The
// request side is ready only when no item is in flight; a finished response
// may wait in its register while the next request is taken, and a run that
// finishes while that register is still full stalls until it drains. Zero
// and the prime itself give no_inverse = 1 without any Euclid step.
// ----------------------------------------------------------------------------
module modular_inverse_prime_core (
	input  logic         clk,
	input  logic         arst_n,
	minv_req_if.sink     req,
	minv_rsp_if.source   rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t               state_q;
	minv_pkg::euclid_t    euclid_q;
	minv_pkg::euclid_t    euclid_nxt;
	minv_pkg::word_t      inverse_q;
	logic                 no_inverse_q;
	logic                 rsp_valid_q;
	logic                 rsp_free;
	logic                 finished;
	logic                 zero_in;

	// shared iteration unit
	minv_step u_step (
		.cur (euclid_q),
		.nxt (euclid_nxt)
	);

	// termination: a remainder hit 1, or the reduced input was zero
	assign zero_in  = (euclid_q.u == '0);
	assign finished = zero_in || (euclid_q.u == minv_pkg::word_t'(1))
		|| (euclid_q.v == minv_pkg::word_t'(1));
	assign rsp_free = !rsp_valid_q || rsp.ready;

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.inverse    = inverse_q;
	assign rsp.no_inverse = no_inverse_q;

	// sequencer with response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// slot empties unless a finishing run refills it at this edge
			if (rsp_valid_q && rsp.ready && !(state_q == ST_RUN && finished)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						euclid_q.u  <= minv_pkg::reduce_mod(req.value);
						euclid_q.v  <= minv_pkg::MODULUS;
						euclid_q.x1 <= minv_pkg::word_t'(1);
						euclid_q.x2 <= '0;
						state_q     <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finished) begin
						// hold the finished word until the response slot frees
						if (rsp_free) begin
							rsp_valid_q  <= 1'b1;
							no_inverse_q <= zero_in;
							if (zero_in) begin
								inverse_q <= '0;
							end else if (euclid_q.u == minv_pkg::word_t'(1)) begin
								inverse_q <= euclid_q.x1;
							end else begin
								inverse_q <= euclid_q.x2;
							end
							state_q <= ST_IDLE;
						end
					end else begin
						euclid_q <= euclid_nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// an accepted word always starts a run
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_RUN)
		else $error("accepted word did not start a run");

	// the two remainders are never both even mid-run
	a_odd_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (euclid_q.u[0] || euclid_q.v[0]))
		else $error("both remainders even");

	// coefficients stay reduced mod p
	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (euclid_q.x1 < minv_pkg::MODULUS)
			&& (euclid_q.x2 < minv_pkg::MODULUS))
		else $error("coefficient out of range");

	// flagged responses carry a zero inverse
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.no_inverse |-> rsp.inverse == '0)
		else $error("no_inverse with non-zero inverse");
`endif

endmodule
